>>> sv/tldn_pkg.sv
// Package for the day/night traffic light controller.
// Holds widths, phase, display and register index codes, register reset values and the state struct.
// No dependencies.
package tldn_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned SecW   = 7;
  localparam int unsigned TickW  = 16;
  localparam int unsigned LightW = 12;
  localparam int unsigned DispW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PhaseW-1:0] PhStopped = 3'd0;
  localparam logic [PhaseW-1:0] PhRed     = 3'd1;
  localparam logic [PhaseW-1:0] PhGreen   = 3'd2;
  localparam logic [PhaseW-1:0] PhYellow  = 3'd3;
  localparam logic [PhaseW-1:0] PhNight   = 3'd4;

  localparam logic [DispW-1:0] DispBlank  = 2'd0;
  localparam logic [DispW-1:0] DispCount  = 2'd1;
  localparam logic [DispW-1:0] DispDashes = 2'd2;

  localparam logic [CfgIdxW-1:0] RegRedSec    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGreenSec  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYellowSec = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTicksSec  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlink     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSample    = 3'd6;

  localparam logic [SecW-1:0]   RedSecRst    = 7'd10;
  localparam logic [SecW-1:0]   GreenSecRst  = 7'd7;
  localparam logic [SecW-1:0]   YellowSecRst = 7'd3;
  localparam logic [TickW-1:0]  TicksSecRst  = 16'd1000;
  localparam logic [TickW-1:0]  BlinkRst     = 16'd400;
  localparam logic [LightW-1:0] ThresholdRst = 12'd2500;
  localparam logic [TickW-1:0]  SampleRst    = 16'd500;

  typedef struct packed {
    logic [PhaseW-1:0] mode;
    logic [SecW-1:0]   remaining;
    logic [TickW-1:0]  sec_cnt;
    logic [TickW-1:0]  blink_cnt;
    logic [TickW-1:0]  sample_cnt;
    logic              blink_phase;
    logic              prev_button;
  } ctrl_state_t;

endpackage

>>> sv/traffic_light_day_night.sv
// Top level of the day/night traffic light controller.
// Depends on tldn_pkg for codes, reset values and the state struct.
//
// One input transfer is one millisecond tick and yields exactly one result
// transfer. The controller state is updated at the input transfer and the
// lamp, countdown and display result is captured in an output register, so a
// tick can be taken on every clock while the result side keeps up. A falling
// edge on button_level starts the cycle at red when stopped and stops it from
// any other phase; while running, the light reading is checked every
// sample_interval ticks and selects night flashing or the normal cycle.
// Configuration writes are always accepted and take effect on the next tick.
module traffic_light_day_night
  import tldn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                button_level_i,
  input  logic [LightW-1:0]   light_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                red_on_o,
  output logic                yellow_on_o,
  output logic                green_on_o,
  output logic                status_on_o,
  output logic [SecW-1:0]     count_shown_o,
  output logic [DispW-1:0]    display_mode_o,
  output logic [PhaseW-1:0]   phase_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [SecW-1:0]   red_sec_q, green_sec_q, yellow_sec_q;
  logic [TickW-1:0]  ticks_sec_q, blink_per_q, sample_int_q;
  logic [LightW-1:0] threshold_q;

  ctrl_state_t st_q, st_d;

  logic              out_valid_q;
  logic              red_q, yellow_q, green_q, status_q;
  logic [SecW-1:0]   count_q;
  logic [DispW-1:0]  disp_q;
  logic [PhaseW-1:0] phase_q;

  logic in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  function automatic logic [TickW-1:0] sat_inc(input logic [TickW-1:0] v);
    return (v == {TickW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic ctrl_state_t go_to(input ctrl_state_t s,
                                        input logic [PhaseW-1:0] nxt,
                                        input logic [SecW-1:0] red_s,
                                        input logic [SecW-1:0] green_s,
                                        input logic [SecW-1:0] yellow_s);
    ctrl_state_t r;
    r           = s;
    r.mode      = nxt;
    r.sec_cnt   = '0;
    r.blink_cnt = '0;
    case (nxt)
      PhRed:    r.remaining = red_s;
      PhGreen:  r.remaining = green_s;
      PhYellow: r.remaining = yellow_s;
      PhNight:  r.blink_phase = 1'b0;
      default:  r.remaining = s.remaining;
    endcase
    return r;
  endfunction

  always_comb begin
    logic running;
    running         = 1'b0;
    st_d            = st_q;
    st_d.sec_cnt    = sat_inc(st_q.sec_cnt);
    st_d.blink_cnt  = sat_inc(st_q.blink_cnt);
    st_d.sample_cnt = sat_inc(st_q.sample_cnt);

    if (!button_level_i && st_q.prev_button) begin
      st_d = go_to(st_d, (st_q.mode == PhStopped) ? PhRed : PhStopped,
                   red_sec_q, green_sec_q, yellow_sec_q);
    end
    st_d.prev_button = button_level_i;

    if (st_d.mode != PhStopped) begin
      if (st_d.sample_cnt >= sample_int_q) begin
        st_d.sample_cnt = '0;
        if (light_level_i > threshold_q && st_d.mode != PhNight) begin
          st_d = go_to(st_d, PhNight, red_sec_q, green_sec_q, yellow_sec_q);
        end else if (light_level_i <= threshold_q && st_d.mode == PhNight) begin
          st_d = go_to(st_d, PhRed, red_sec_q, green_sec_q, yellow_sec_q);
        end
      end
      running = (st_d.mode == PhRed) || (st_d.mode == PhGreen) ||
                (st_d.mode == PhYellow);
      if (running) begin
        if (st_d.sec_cnt >= ticks_sec_q) begin
          st_d.sec_cnt = '0;
          if (st_d.remaining <= 7'd1) begin
            st_d.remaining = '0;
            case (st_d.mode)
              PhRed:   st_d = go_to(st_d, PhGreen, red_sec_q, green_sec_q, yellow_sec_q);
              PhGreen: st_d = go_to(st_d, PhYellow, red_sec_q, green_sec_q, yellow_sec_q);
              default: st_d = go_to(st_d, PhRed, red_sec_q, green_sec_q, yellow_sec_q);
            endcase
          end else begin
            st_d.remaining = st_d.remaining - 1'b1;
          end
        end
      end else if (st_d.mode == PhNight) begin
        if (st_d.blink_cnt >= blink_per_q) begin
          st_d.blink_cnt   = '0;
          st_d.blink_phase = !st_d.blink_phase;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_sec_q    <= RedSecRst;
      green_sec_q  <= GreenSecRst;
      yellow_sec_q <= YellowSecRst;
      ticks_sec_q  <= TicksSecRst;
      blink_per_q  <= BlinkRst;
      threshold_q  <= ThresholdRst;
      sample_int_q <= SampleRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRedSec:    red_sec_q    <= cfg_data_i[SecW-1:0];
        RegGreenSec:  green_sec_q  <= cfg_data_i[SecW-1:0];
        RegYellowSec: yellow_sec_q <= cfg_data_i[SecW-1:0];
        RegTicksSec:  ticks_sec_q  <= cfg_data_i[TickW-1:0];
        RegBlink:     blink_per_q  <= cfg_data_i[TickW-1:0];
        RegThreshold: threshold_q  <= cfg_data_i[LightW-1:0];
        RegSample:    sample_int_q <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode        <= PhStopped;
      st_q.remaining   <= '0;
      st_q.sec_cnt     <= '0;
      st_q.blink_cnt   <= '0;
      st_q.sample_cnt  <= '0;
      st_q.blink_phase <= 1'b0;
      st_q.prev_button <= 1'b1;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_q <= st_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      red_q    <= (st_d.mode == PhRed);
      yellow_q <= (st_d.mode == PhYellow) || (st_d.mode == PhNight && st_d.blink_phase);
      green_q  <= (st_d.mode == PhGreen);
      status_q <= (st_d.mode == PhStopped);
      count_q  <= ((st_d.mode == PhRed) || (st_d.mode == PhGreen) ||
                   (st_d.mode == PhYellow)) ? st_d.remaining : '0;
      disp_q   <= (st_d.mode == PhStopped) ? DispBlank :
                  (st_d.mode == PhNight) ? DispDashes : DispCount;
      phase_q  <= st_d.mode;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_on_o       = red_q;
  assign yellow_on_o    = yellow_q;
  assign green_on_o     = green_q;
  assign status_on_o    = status_q;
  assign count_shown_o  = count_q;
  assign display_mode_o = disp_q;
  assign phase_o        = phase_q;

endmodule

>>> tb/sv/tldn_lamp_checker.sv
`timescale 1ns / 1ps
// Checker for the day/night traffic light controller: predicts each tick's result and
// compares it field by field with the result channel. Depends on tldn_pkg.
module tldn_lamp_checker
  import tldn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                button_level_i,
  input  logic [LightW-1:0]   light_level_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                red_on_i,
  input  logic                yellow_on_i,
  input  logic                green_on_i,
  input  logic                status_on_i,
  input  logic [SecW-1:0]     count_shown_i,
  input  logic [DispW-1:0]    display_mode_i,
  input  logic [PhaseW-1:0]   phase_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic              red;
    logic              yellow;
    logic              green;
    logic              status;
    logic [SecW-1:0]   count;
    logic [DispW-1:0]  disp;
    logic [PhaseW-1:0] phase;
  } lamp_result_t;

  logic [SecW-1:0]   red_sec, green_sec, yellow_sec;
  logic [TickW-1:0]  ticks_sec, blink_per, sample_ivl;
  logic [LightW-1:0] thresh;
  ctrl_state_t       st;
  lamp_result_t      lamp_expect_q[$];
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [TickW-1:0] sat_up(input logic [TickW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic enter_phase(input logic [PhaseW-1:0] nxt);
    st.mode = nxt;
    st.sec_cnt = '0;
    st.blink_cnt = '0;
    case (nxt)
      PhRed: begin
        st.remaining = red_sec;
      end
      PhGreen: begin
        st.remaining = green_sec;
      end
      PhYellow: begin
        st.remaining = yellow_sec;
      end
      PhNight: begin
        st.blink_phase = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      RegRedSec: begin
        red_sec = data[SecW-1:0];
      end
      RegGreenSec: begin
        green_sec = data[SecW-1:0];
      end
      RegYellowSec: begin
        yellow_sec = data[SecW-1:0];
      end
      RegTicksSec: begin
        ticks_sec = data[TickW-1:0];
      end
      RegBlink: begin
        blink_per = data[TickW-1:0];
      end
      RegThreshold: begin
        thresh = data[LightW-1:0];
      end
      RegSample: begin
        sample_ivl = data[TickW-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // One millisecond tick: counters, button edge, light sample, then countdown or blink.
  task automatic tick_controller(input logic btn, input logic [LightW-1:0] lux);
    st.sec_cnt = sat_up(st.sec_cnt);
    st.blink_cnt = sat_up(st.blink_cnt);
    st.sample_cnt = sat_up(st.sample_cnt);
    if (!btn && st.prev_button) begin
      enter_phase((st.mode == PhStopped) ? PhRed : PhStopped);
    end
    st.prev_button = btn;
    if (st.mode != PhStopped) begin
      if (st.sample_cnt >= sample_ivl) begin
        st.sample_cnt = '0;
        if (lux > thresh && st.mode != PhNight) begin
          enter_phase(PhNight);
        end else if (lux <= thresh && st.mode == PhNight) begin
          enter_phase(PhRed);
        end
      end
      if (st.mode == PhRed || st.mode == PhGreen || st.mode == PhYellow) begin
        if (st.sec_cnt >= ticks_sec) begin
          st.sec_cnt = '0;
          if (st.remaining <= 1) begin
            st.remaining = '0;
            case (st.mode)
              PhRed: begin
                enter_phase(PhGreen);
              end
              PhGreen: begin
                enter_phase(PhYellow);
              end
              default: begin
                enter_phase(PhRed);
              end
            endcase
          end else begin
            st.remaining = st.remaining - 1'b1;
          end
        end
      end else if (st.mode == PhNight) begin
        if (st.blink_cnt >= blink_per) begin
          st.blink_cnt = '0;
          st.blink_phase = ~st.blink_phase;
        end
      end
    end
  endtask

  function automatic lamp_result_t lamp_outputs();
    lamp_result_t r;
    r.red = (st.mode == PhRed);
    r.yellow = (st.mode == PhYellow) || (st.mode == PhNight && st.blink_phase);
    r.green = (st.mode == PhGreen);
    r.status = (st.mode == PhStopped);
    r.count = (st.mode == PhRed || st.mode == PhGreen || st.mode == PhYellow) ?
              st.remaining : '0;
    r.disp = (st.mode == PhStopped) ? DispBlank :
             ((st.mode == PhNight) ? DispDashes : DispCount);
    r.phase = st.mode;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    lamp_result_t want;
    if (!rst_ni) begin
      red_sec = RedSecRst;
      green_sec = GreenSecRst;
      yellow_sec = YellowSecRst;
      ticks_sec = TicksSecRst;
      blink_per = BlinkRst;
      thresh = ThresholdRst;
      sample_ivl = SampleRst;
      st.mode = PhStopped;
      st.remaining = '0;
      st.sec_cnt = '0;
      st.blink_cnt = '0;
      st.sample_cnt = '0;
      st.blink_phase = 1'b0;
      st.prev_button = 1'b1;
      lamp_expect_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        apply_reg(cfg_index_i, cfg_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        tick_controller(button_level_i, light_level_i);
        lamp_expect_q.push_back(lamp_outputs());
      end
      if (out_valid_i && out_ready_i) begin
        if (lamp_expect_q.size() == 0) begin
          $error("Result transfer arrived with no tick waiting for it.");
          mismatches++;
        end else begin
          want = lamp_expect_q.pop_front();
          check_field("red_on", 32'(want.red), 32'(red_on_i));
          check_field("yellow_on", 32'(want.yellow), 32'(yellow_on_i));
          check_field("green_on", 32'(want.green), 32'(green_on_i));
          check_field("status_on", 32'(want.status), 32'(status_on_i));
          check_field("count_shown", 32'(want.count), 32'(count_shown_i));
          check_field("display_mode", 32'(want.disp), 32'(display_mode_i));
          check_field("phase", 32'(want.phase), 32'(phase_i));
        end
      end
    end
    pending_o <= lamp_expect_q.size();
  end

endmodule

>>> tb/sv/tb_traffic_light_day_night.sv
`timescale 1ns / 1ps
// Testbench top for the day/night traffic light controller: clock, reset, tick and
// register stimulus, verdict. Depends on tldn_pkg, traffic_light_day_night, tldn_lamp_checker.
module tb_traffic_light_day_night;
  import tldn_pkg::*;

  localparam logic [CfgIdxW-1:0] RegNone = 3'd7;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned TicksPerPhase = 230;
  localparam int unsigned HoldCycles = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                button_level_i;
  logic [LightW-1:0]   light_level_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                red_on_o;
  logic                yellow_on_o;
  logic                green_on_o;
  logic                status_on_o;
  logic [SecW-1:0]     count_shown_o;
  logic [DispW-1:0]    display_mode_o;
  logic [PhaseW-1:0]   phase_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int                fail_count;
  int                pending;
  int                tx_idle_pct;
  int                rx_stall_pct;
  bit                hold_armed;
  bit                hold_done;
  int                hold_left;
  logic [LightW-1:0] cur_thr;

  traffic_light_day_night dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .button_level_i (button_level_i),
    .light_level_i  (light_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_on_o       (red_on_o),
    .yellow_on_o    (yellow_on_o),
    .green_on_o     (green_on_o),
    .status_on_o    (status_on_o),
    .count_shown_o  (count_shown_o),
    .display_mode_o (display_mode_o),
    .phase_o        (phase_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  tldn_lamp_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .button_level_i (button_level_i),
    .light_level_i  (light_level_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_on_i       (red_on_o),
    .yellow_on_i    (yellow_on_o),
    .green_on_i     (green_on_o),
    .status_on_i    (status_on_o),
    .count_shown_i  (count_shown_o),
    .display_mode_i (display_mode_o),
    .phase_i        (phase_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(300_000 * 12);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off once it is armed.
  initial begin
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_tick(input logic btn, input logic [LightW-1:0] lux);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_level_i <= btn;
    light_level_i <= lux;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Unused upper data bits carry random junk that the block must drop.
  task automatic program_regs(input logic [SecW-1:0] red, input logic [SecW-1:0] green,
                              input logic [SecW-1:0] yellow, input logic [TickW-1:0] tps,
                              input logic [TickW-1:0] blink, input logic [LightW-1:0] thr,
                              input logic [TickW-1:0] smp);
    write_reg(RegRedSec, {9'($urandom), red});
    write_reg(RegGreenSec, {9'($urandom), green});
    write_reg(RegYellowSec, {9'($urandom), yellow});
    write_reg(RegTicksSec, tps);
    write_reg(RegBlink, blink);
    write_reg(RegThreshold, {4'($urandom), thr});
    write_reg(RegSample, smp);
    cur_thr = thr;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Mostly released button with short presses; light drifts between dark and
  // bright spells around the current threshold, with some fully random readings.
  task automatic run_traffic(input int unsigned count);
    logic              btn;
    logic [LightW-1:0] lux;
    int unsigned       press_left;
    bit                dark;
    press_left = 0;
    dark = 1'b0;
    for (int unsigned k = 0; k < count; k++) begin
      if (press_left == 0 && $urandom_range(99) < 2) begin
        press_left = $urandom_range(4, 1);
      end
      btn = (press_left == 0);
      if (press_left != 0) begin
        press_left--;
      end
      if ($urandom_range(99) < 4) begin
        dark = !dark;
      end
      if ($urandom_range(99) < 10) begin
        lux = LightW'($urandom);
      end else if (dark && cur_thr != '1) begin
        lux = LightW'($urandom_range(4095, cur_thr + 1));
      end else begin
        lux = LightW'($urandom_range(cur_thr, 0));
      end
      send_tick(btn, lux);
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    button_level_i = 1'b1;
    light_level_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegRedSec;
    cfg_data_i = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_armed = 1'b0;
    cur_thr = ThresholdRst;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start, night entry and exit, stop while night, restart and the threshold itself.
    program_regs(7'd1, 7'd2, 7'd1, 16'd1, 16'd1, 12'd2000, 16'd2);
    send_tick(1'b1, 12'd0);
    send_tick(1'b0, 12'd0);
    send_tick(1'b0, 12'd0);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b0, 12'd4095);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b0, 12'd4095);
    send_tick(1'b1, 12'd2001);
    send_tick(1'b1, 12'd2001);
    send_tick(1'b1, 12'd2000);
    send_tick(1'b1, 12'd2000);
    wait_drained();

    // All intervals and countdowns zero: every event fires on every tick.
    write_reg(RegNone, CfgDataW'($urandom));
    program_regs(7'd0, 7'd0, 7'd0, 16'd0, 16'd0, 12'd0, 16'd0);
    send_tick(1'b0, 12'd0);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'd0);
    send_tick(1'b1, 12'd1);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b1, 12'd4095);
    send_tick(1'b1, 12'd0);
    send_tick(1'b0, 12'd0);

    for (int p = 0; p < RandPhases; p++) begin
      wait_drained();
      case (p)
        1: program_regs(7'd99, 7'd99, 7'd99, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'hFFFF);
        3: program_regs(7'd0, 7'd0, 7'd0, 16'd0, 16'd0, 12'd0, 16'd0);
        5: program_regs(7'($urandom_range(99, 1)), 7'($urandom_range(99, 1)),
                        7'($urandom_range(99, 1)), 16'($urandom_range(3, 1)),
                        16'($urandom_range(8, 1)), 12'($urandom), 16'($urandom_range(50, 1)));
        default: program_regs(7'($urandom_range(4)), 7'($urandom_range(4)),
                              7'($urandom_range(4)), 16'($urandom_range(4)),
                              16'($urandom_range(5)), 12'($urandom), 16'($urandom_range(20)));
      endcase
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 51;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 51;
        end
        default: begin
          tx_idle_pct = 33;
          rx_stall_pct = 33;
        end
      endcase
      if (p == 4) begin
        hold_armed = 1'b1;
      end
      run_traffic(TicksPerPhase);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
